@@ sv/kmhl_pkg.sv @@
// ----------------------------------------------------------------------------
// kmhl_pkg
// Shared types and constants of the k-way merge head list.
// ----------------------------------------------------------------------------
package kmhl_pkg;

   localparam int IN_KEY_BITS    = 32;
   localparam int STREAM_BITS    = 4;
   localparam int COUNT_OUT_BITS = 5;
   localparam int STATUS_BITS    = 2;

   // request function codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_POP    = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK        = 2'd0,
      STAT_POP_EMPTY = 2'd1,
      STAT_INS_FULL  = 2'd2
   } rsp_status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } list_op_type;

   // command from controller to list datapath
   typedef struct packed {
      logic        valid;
      list_op_type op;
   } list_cmd_type;

endpackage

@@ sv/kmhl_ctrl.sv @@
// ----------------------------------------------------------------------------
// kmhl_ctrl
// Handshake controller: accepts items, issues list commands and tracks the
// result register.
// ----------------------------------------------------------------------------
module kmhl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kmhl_pkg::list_cmd_type cmd
);
   import kmhl_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   // result register frees up in the same cycle it is taken
   assign req_ready = (state_ff == ST_IDLE) || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_HOLD);

   always_comb begin
      cmd.valid = accept;
      cmd.op    = (req_func == FUNC_POP) ? OP_POP : OP_INSERT;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (!accept && rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/kmhl_list.sv @@
// ----------------------------------------------------------------------------
// kmhl_list
// Sorted compare-and-shift list of head entries with the result register.
// ----------------------------------------------------------------------------
module kmhl_list #(
   parameter int NUM_STREAMS = 16,
   parameter int KEY_BITS    = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  kmhl_pkg::list_cmd_type                cmd,
   input  logic [kmhl_pkg::IN_KEY_BITS-1:0]      req_key,
   input  logic [kmhl_pkg::STREAM_BITS-1:0]      req_stream,
   output logic                                  rsp_popped_valid,
   output logic [kmhl_pkg::IN_KEY_BITS-1:0]      rsp_popped_key,
   output logic [kmhl_pkg::STREAM_BITS-1:0]      rsp_popped_stream,
   output logic                                  rsp_list_empty,
   output logic [kmhl_pkg::COUNT_OUT_BITS-1:0]   rsp_entry_count,
   output logic [kmhl_pkg::STATUS_BITS-1:0]      rsp_status
);
   import kmhl_pkg::*;

   localparam int CW = $clog2(NUM_STREAMS + 1);

   logic [KEY_BITS-1:0]    key_ff    [NUM_STREAMS];
   logic [STREAM_BITS-1:0] stream_ff [NUM_STREAMS];
   logic [KEY_BITS-1:0]    key_in    [NUM_STREAMS];
   logic [STREAM_BITS-1:0] stream_in [NUM_STREAMS];
   logic [NUM_STREAMS-1:0] gt;

   logic [CW-1:0]       count_ff, count_in;
   logic [KEY_BITS-1:0] new_key;
   logic                full, empty, do_ins, do_pop;
   rsp_status_type      status_in;

   logic                      pv_ff;
   logic [IN_KEY_BITS-1:0]    pkey_ff;
   logic [STREAM_BITS-1:0]    pstream_ff;
   logic                      empty_ff;
   logic [COUNT_OUT_BITS-1:0] cnt_ff;
   rsp_status_type            status_ff;

   assign new_key = KEY_BITS'(req_key);
   assign full    = (count_ff == CW'(NUM_STREAMS));
   assign empty   = (count_ff == '0);
   assign do_ins  = cmd.valid && (cmd.op == OP_INSERT) && !full;
   assign do_pop  = cmd.valid && (cmd.op == OP_POP) && !empty;

   // each cell compares against the new key; unheld cells count as greater
   for (genvar i = 0; i < NUM_STREAMS; i++) begin : g_cell
      assign gt[i] = (count_ff <= CW'(i)) || (key_ff[i] > new_key);

      if (i == 0) begin : g_first
         always_comb begin
            if (do_ins && gt[0]) begin
               key_in[0]    = new_key;
               stream_in[0] = req_stream;
            end else if (do_pop) begin
               key_in[0]    = key_ff[1];
               stream_in[0] = stream_ff[1];
            end else begin
               key_in[0]    = key_ff[0];
               stream_in[0] = stream_ff[0];
            end
         end
      end else begin : g_rest
         always_comb begin
            key_in[i]    = key_ff[i];
            stream_in[i] = stream_ff[i];
            if (do_ins && gt[i]) begin
               if (gt[i-1]) begin
                  key_in[i]    = key_ff[i-1];
                  stream_in[i] = stream_ff[i-1];
               end else begin
                  key_in[i]    = new_key;
                  stream_in[i] = req_stream;
               end
            end else if (do_pop && (i < NUM_STREAMS - 1)) begin
               key_in[i]    = key_ff[(i + 1) % NUM_STREAMS];
               stream_in[i] = stream_ff[(i + 1) % NUM_STREAMS];
            end
         end
      end

      always_ff @(posedge clock) begin
         key_ff[i]    <= key_in[i];
         stream_ff[i] <= stream_in[i];
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = STAT_OK;
      if (cmd.valid) begin
         case (cmd.op)
            OP_INSERT: begin
               if (full) status_in = STAT_INS_FULL;
               else      count_in  = count_ff + CW'(1);
            end
            OP_POP: begin
               if (empty) status_in = STAT_POP_EMPTY;
               else       count_in  = count_ff - CW'(1);
            end
            default: status_in = STAT_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // result register, loaded once per accepted item
   always_ff @(posedge clock) begin
      if (cmd.valid) begin
         pv_ff      <= do_pop;
         pkey_ff    <= do_pop ? IN_KEY_BITS'(key_ff[0]) : '0;
         pstream_ff <= do_pop ? stream_ff[0] : '0;
         empty_ff   <= (count_in == '0);
         cnt_ff     <= COUNT_OUT_BITS'(count_in);
         status_ff  <= status_in;
      end
   end

   assign rsp_popped_valid  = pv_ff;
   assign rsp_popped_key    = pkey_ff;
   assign rsp_popped_stream = pstream_ff;
   assign rsp_list_empty    = empty_ff;
   assign rsp_entry_count   = cnt_ff;
   assign rsp_status        = status_ff;

endmodule

@@ sv/kway_merge_head_list.sv @@
// ----------------------------------------------------------------------------
// kway_merge_head_list
// Head list of a k-way merge: sorted insert and pop-smallest of stream heads.
// ----------------------------------------------------------------------------
// Each item is an insert (req_func 0) or a pop (req_func 1). Every item gives
// one result, registered, in the cycle after acceptance; a new item is taken
// whenever the result register is free or its result is being taken, so the
// block sustains one item per clock unless the receiver stalls. That figure
// is set by the list itself: all NUM_STREAMS cells compare their key against
// the new key in parallel and shift by one place. Equal keys leave in arrival
// order. Pop on an empty list returns status 1, insert into a full list drops
// the entry and returns status 2. Keys are held at KEY_BITS bits.
module kway_merge_head_list #(
   parameter int NUM_STREAMS = 16,
   parameter int KEY_BITS    = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_func,
   input  logic [kmhl_pkg::IN_KEY_BITS-1:0]      req_key,
   input  logic [kmhl_pkg::STREAM_BITS-1:0]      req_stream,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_popped_valid,
   output logic [kmhl_pkg::IN_KEY_BITS-1:0]      rsp_popped_key,
   output logic [kmhl_pkg::STREAM_BITS-1:0]      rsp_popped_stream,
   output logic                                  rsp_list_empty,
   output logic [kmhl_pkg::COUNT_OUT_BITS-1:0]   rsp_entry_count,
   output logic [kmhl_pkg::STATUS_BITS-1:0]      rsp_status
);
   import kmhl_pkg::*;

   list_cmd_type cmd;

   kmhl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   kmhl_list #(
      .NUM_STREAMS (NUM_STREAMS),
      .KEY_BITS    (KEY_BITS)
   ) u_list (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_key           (req_key),
      .req_stream        (req_stream),
      .rsp_popped_valid  (rsp_popped_valid),
      .rsp_popped_key    (rsp_popped_key),
      .rsp_popped_stream (rsp_popped_stream),
      .rsp_list_empty    (rsp_list_empty),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_status        (rsp_status)
   );

endmodule

@@ sv/kmhl_checker.sv @@
// ----------------------------------------------------------------------------
// kmhl_props
// Port-level checks of the merge head list, bound to the top level.
// ----------------------------------------------------------------------------
module kmhl_props (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic                                  rsp_popped_valid,
   input logic [kmhl_pkg::IN_KEY_BITS-1:0]      rsp_popped_key,
   input logic [kmhl_pkg::STREAM_BITS-1:0]      rsp_popped_stream,
   input logic                                  rsp_list_empty,
   input logic [kmhl_pkg::COUNT_OUT_BITS-1:0]   rsp_entry_count,
   input logic [kmhl_pkg::STATUS_BITS-1:0]      rsp_status
);
   import kmhl_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_popped_key)
         && $stable(rsp_status) && $stable(rsp_entry_count))
      else $error("result changed while stalled");

   // every accepted item gives a result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item without result");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_list_empty == (rsp_entry_count == '0))
      else $error("empty flag disagrees with count");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_POP_EMPTY |->
         rsp_list_empty && !rsp_popped_valid && rsp_popped_stream == '0)
      else $error("bad result for pop on empty list");

   a_popped_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_popped_valid |-> rsp_status == STAT_OK)
      else $error("popped entry with error status");

endmodule

bind kway_merge_head_list kmhl_props u_kmhl_props (.*);

@@ sim/kmhl_checker.sv @@
// ----------------------------------------------------------------------------
// kmhl_checker
// Watches both channels of the merge head list and checks each result item.
// ----------------------------------------------------------------------------
// Every accepted request item is run through a local copy of the sorted head
// list, and the expected result is queued. Each accepted result item is
// compared field by field with the oldest queued one. The failure count and
// the number of outstanding results are handed back to the testbench top.
module kmhl_checker #(
   parameter int NUM_STREAMS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic                                  req_func,
   input  logic [kmhl_pkg::IN_KEY_BITS-1:0]      req_key,
   input  logic [kmhl_pkg::STREAM_BITS-1:0]      req_stream,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic                                  rsp_popped_valid,
   input  logic [kmhl_pkg::IN_KEY_BITS-1:0]      rsp_popped_key,
   input  logic [kmhl_pkg::STREAM_BITS-1:0]      rsp_popped_stream,
   input  logic                                  rsp_list_empty,
   input  logic [kmhl_pkg::COUNT_OUT_BITS-1:0]   rsp_entry_count,
   input  logic [kmhl_pkg::STATUS_BITS-1:0]      rsp_status,
   output int                                    fail_count,
   output int                                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import kmhl_pkg::*;

   typedef struct {
      logic [IN_KEY_BITS-1:0] key;
      logic [STREAM_BITS-1:0] stream;
   } head_entry_type;

   typedef struct {
      logic                      popped_valid;
      logic [IN_KEY_BITS-1:0]    popped_key;
      logic [STREAM_BITS-1:0]    popped_stream;
      logic                      list_empty;
      logic [COUNT_OUT_BITS-1:0] entry_count;
      rsp_status_type            status;
   } list_result_type;

   head_entry_type  head_entries[NUM_STREAMS];
   int              heads_held = 0;
   int              mismatches = 0;
   list_result_type expected_results_q[$];

   // Sorted insert after the last entry with an equal or smaller key, or pop
   // of the smallest entry. Updates the local list and returns the result.
   function automatic list_result_type step_head_list(
      input logic                   func,
      input logic [IN_KEY_BITS-1:0] key,
      input logic [STREAM_BITS-1:0] stream
   );
      list_result_type r;
      int              pos;
      r.popped_valid  = 1'b0;
      r.popped_key    = '0;
      r.popped_stream = '0;
      r.status        = STAT_OK;
      if (func == FUNC_INSERT) begin
         if (heads_held >= NUM_STREAMS) begin
            r.status = STAT_INS_FULL;
         end else begin
            pos = heads_held;
            for (int j = 0; j < heads_held; j++) begin
               if (head_entries[j].key > key) begin
                  pos = j;
                  break;
               end
            end
            for (int j = heads_held; j > pos; j--)
               head_entries[j] = head_entries[j-1];
            head_entries[pos].key    = key;
            head_entries[pos].stream = stream;
            heads_held++;
         end
      end else if (heads_held == 0) begin
         r.status = STAT_POP_EMPTY;
      end else begin
         r.popped_valid  = 1'b1;
         r.popped_key    = head_entries[0].key;
         r.popped_stream = head_entries[0].stream;
         for (int j = 1; j < heads_held; j++)
            head_entries[j-1] = head_entries[j];
         heads_held--;
      end
      r.list_empty  = (heads_held == 0);
      r.entry_count = COUNT_OUT_BITS'(heads_held);
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_val,
                                       input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      list_result_type exp_r;
      if (reset) begin
         heads_held = 0;
         expected_results_q.delete();
      end else begin
         // a result item at this edge always belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            if (expected_results_q.size() == 0) begin
               $error("result item with no request outstanding");
               mismatches++;
            end else begin
               exp_r = expected_results_q[0];
               expected_results_q.delete(0);
               check_field("popped_valid", 32'(exp_r.popped_valid), 32'(rsp_popped_valid));
               check_field("popped_key", 32'(exp_r.popped_key), 32'(rsp_popped_key));
               check_field("popped_stream", 32'(exp_r.popped_stream),
                           32'(rsp_popped_stream));
               check_field("list_empty", 32'(exp_r.list_empty), 32'(rsp_list_empty));
               check_field("entry_count", 32'(exp_r.entry_count), 32'(rsp_entry_count));
               check_field("status", 32'(exp_r.status), 32'(rsp_status));
            end
         end
         if (req_valid && req_ready)
            expected_results_q.insert(expected_results_q.size(),
                                      step_head_list(req_func, req_key, req_stream));
      end
      pending    <= expected_results_q.size();
      fail_count <= mismatches;
   end

endmodule

@@ sim/tb_kway_merge_head_list.sv @@
// ----------------------------------------------------------------------------
// tb_kway_merge_head_list
// Testbench of the k-way merge head list.
// ----------------------------------------------------------------------------
// A directed run covers pop on empty, extreme and equal keys, a full list and
// insert into it. Random merge traffic follows: pop and refill pairs, runs up
// to full and down to empty, and some noise, with bursty sending and a
// stalling receiver, including one long hold-off. Results are checked by
// kmhl_checker.
module tb_kway_merge_head_list;
   timeunit 1ns;
   timeprecision 1ps;

   import kmhl_pkg::*;

   localparam int NUM_HEADS   = 16;
   localparam int TOTAL_ITEMS = 1200;
   localparam int LONG_HOLD   = 150;
   localparam int IDLE_LIMIT  = 5000;

   localparam logic [IN_KEY_BITS-1:0] DIRECTED_KEYS [NUM_HEADS] = '{
      32'd5, 32'hFFFF_FFFF, 32'd0, 32'd5, 32'd5, 32'd7, 32'd0, 32'hFFFF_FFFF,
      32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFE, 32'd5, 32'hAAAA_AAAA,
      32'h5555_5555, 32'd3
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_func = FUNC_INSERT;
   logic [IN_KEY_BITS-1:0]    req_key = '0;
   logic [STREAM_BITS-1:0]    req_stream = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_popped_valid;
   logic [IN_KEY_BITS-1:0]    rsp_popped_key;
   logic [STREAM_BITS-1:0]    rsp_popped_stream;
   logic                      rsp_list_empty;
   logic [COUNT_OUT_BITS-1:0] rsp_entry_count;
   logic [STATUS_BITS-1:0]    rsp_status;

   int fail_count;
   int pending;
   int items_sent  = 0;
   int occupancy   = 0;
   int burst_left  = 0;
   int idle_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   kway_merge_head_list #(
      .NUM_STREAMS (NUM_HEADS),
      .KEY_BITS    (IN_KEY_BITS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_key           (req_key),
      .req_stream        (req_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_popped_valid  (rsp_popped_valid),
      .rsp_popped_key    (rsp_popped_key),
      .rsp_popped_stream (rsp_popped_stream),
      .rsp_list_empty    (rsp_list_empty),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_status        (rsp_status)
   );

   kmhl_checker #(
      .NUM_STREAMS (NUM_HEADS)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_key           (req_key),
      .req_stream        (req_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_popped_valid  (rsp_popped_valid),
      .rsp_popped_key    (rsp_popped_key),
      .rsp_popped_stream (rsp_popped_stream),
      .rsp_list_empty    (rsp_list_empty),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_status        (rsp_status),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   // small ranges give plenty of equal keys, the rest spreads over all bits
   function automatic logic [IN_KEY_BITS-1:0] pick_key();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return IN_KEY_BITS'($urandom_range(0, 7));
         5:       return 32'hFFFF_FFF0 + IN_KEY_BITS'($urandom_range(0, 15));
         default: return $urandom();
      endcase
   endfunction

   // called just after a rising edge; returns just after the accepting edge
   task automatic send_item(input logic func, input logic [IN_KEY_BITS-1:0] key,
                            input logic [STREAM_BITS-1:0] stream);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_func   <= func;
      req_key    <= key;
      req_stream <= stream;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (func == FUNC_INSERT && occupancy < NUM_HEADS)
         occupancy++;
      else if (func == FUNC_POP && occupancy > 0)
         occupancy--;
   endtask

   task automatic send_insert();
      send_item(FUNC_INSERT, pick_key(), STREAM_BITS'($urandom_range(0, 15)));
   endtask

   task automatic send_pop();
      send_item(FUNC_POP, $urandom(), STREAM_BITS'($urandom_range(0, 15)));
   endtask

   // receiver: stretches of steady, random and mostly stalled ready, and one
   // long hold-off while the sender keeps offering items
   initial begin
      int  stretch;
      int  mode;
      bit  long_hold_done;
      long_hold_done = 1'b0;
      forever begin
         if (!long_hold_done && items_sent >= 400) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(1, 40);
         repeat (stretch) begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 4) != 0);
               default: rsp_ready <= ($urandom_range(0, 5) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_kway_merge_head_list failed");
            $finish;
         end
      end
   end

   initial begin
      int extra;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: pop on empty, fill with extreme and equal keys, overfill
      send_item(FUNC_POP, '1, '1);
      for (int i = 0; i < NUM_HEADS; i++)
         send_item(FUNC_INSERT, DIRECTED_KEYS[i], STREAM_BITS'(i));
      send_item(FUNC_INSERT, '0, '0);
      send_item(FUNC_INSERT, '1, '1);
      repeat (6) send_pop();

      while (items_sent < TOTAL_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               // merge step: take the smallest head, insert a new head from a random stream
               if (occupancy == 0) begin
                  send_insert();
               end else begin
                  send_pop();
                  if (occupancy < NUM_HEADS)
                     send_insert();
               end
            end
            6, 7: begin
               while (occupancy < NUM_HEADS) send_insert();
               extra = $urandom_range(1, 2);
               repeat (extra) send_insert();
            end
            8: begin
               while (occupancy > 0) send_pop();
               extra = $urandom_range(1, 2);
               repeat (extra) send_pop();
            end
            default: begin
               extra = $urandom_range(1, 4);
               repeat (extra)
                  send_item(1'($urandom_range(0, 1)), $urandom(),
                            STREAM_BITS'($urandom_range(0, 15)));
            end
         endcase
      end
      req_valid <= 1'b0;

      // the outstanding count is registered and lags the last accepted item
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("tb_kway_merge_head_list passed");
      else
         $display("tb_kway_merge_head_list failed");
      $finish;
   end

endmodule
